### src/xxh32_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh32_pkg
// Shared constants, types and helpers for the streaming xxHash32 block.
// ----------------------------------------------------------------------------
package xxh32_pkg;

	localparam logic [31:0] PRIME1 = 32'h9E3779B1;
	localparam logic [31:0] PRIME2 = 32'h85EBCA77;
	localparam logic [31:0] PRIME3 = 32'hC2B2AE3D;
	localparam logic [31:0] PRIME4 = 32'h27D4EB2F;
	localparam logic [31:0] PRIME5 = 32'h165667B1;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_LANE_A,
		S_LANE_B,
		S_INIT,
		S_PEND_A,
		S_PEND_B,
		S_BYTE_A,
		S_BYTE_B,
		S_AVAL_A,
		S_AVAL_B,
		S_OUT
	} state_t;

	// datapath operations, one per cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_LANE_A,
		OP_LANE_B,
		OP_INIT,
		OP_PEND_A,
		OP_PEND_B,
		OP_BYTE_A,
		OP_BYTE_B,
		OP_AVAL_A,
		OP_AVAL_B,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] idx;
	} dp_cmd_t;

	typedef struct packed {
		logic       full_stripe;
		logic       item_last;
		logic [1:0] pcnt;
		logic [1:0] tail;
		logic       last;
		logic       out_free;
	} dp_stat_t;

	// rotate left by a constant amount in 1..31
	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

endpackage

### src/xxhash32_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxhash32_stream
// Streaming 32-bit xxHash of a message of little-endian words.
// ----------------------------------------------------------------------------
// Input channel (item_valid / item_stall) carries one word per transfer with
// seed, byte_count and last; the seed is taken on the first word of each
// message. Output channel (hash_valid / hash_stall) carries one hash per
// message, after the transfer marked last.
// A word that neither completes a stripe of four nor is last is taken
// without a stall. A word that completes a stripe runs four lane rounds of
// two dependent multiplies each through the single shared multiplier, with
// the input stalled until they are done.
// The last word then runs the merge, a round per buffered word (0..3), a
// round per tail byte (0..3), the avalanche and the load of the output
// register; the hash appears the cycle after that load.
// Reset clears the message state; the first transfer after reset starts a
// new message. A stalled output holds its hash; the block keeps accepting
// words meanwhile, and only the next result waits for the output register,
// with the input stalled until that register frees up.
// ----------------------------------------------------------------------------
module xxhash32_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [31:0] seed,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,
	output logic        hash_valid,
	input  logic        hash_stall,
	output logic [31:0] hash
);

	xxh32_pkg::dp_cmd_t  cmd;
	xxh32_pkg::dp_stat_t stat;

	// sequencer
	xxh32_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath
	xxh32_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed       (seed),
		.data_word  (data_word),
		.byte_count (byte_count),
		.last       (last),
		.hash_stall (hash_stall),
		.hash_valid (hash_valid),
		.hash       (hash),
		.cmd        (cmd),
		.stat       (stat)
	);

endmodule

### src/xxh32_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh32_ctrl
// Sequencer: accepts items and steps the datapath through stripe rounds,
// the pending word and tail byte rounds, the avalanche and the output.
// ----------------------------------------------------------------------------
module xxh32_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  xxh32_pkg::dp_stat_t stat,
	output xxh32_pkg::dp_cmd_t  cmd
);

	xxh32_pkg::state_t state_q, state_d;
	logic [1:0]        idx_q, idx_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xxh32_pkg::S_IDLE;
			idx_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		item_stall = 1'b1;
		cmd.op     = xxh32_pkg::OP_NONE;
		cmd.idx    = idx_q;
		unique case (state_q)
			xxh32_pkg::S_IDLE: begin
				item_stall = 1'b0;
				idx_d      = 2'd0;
				if (item_valid) begin
					cmd.op = xxh32_pkg::OP_LOAD;
					if (stat.full_stripe)
						state_d = xxh32_pkg::S_LANE_A;
					else if (stat.item_last)
						state_d = xxh32_pkg::S_INIT;
				end
			end
			xxh32_pkg::S_LANE_A: begin
				cmd.op  = xxh32_pkg::OP_LANE_A;
				state_d = xxh32_pkg::S_LANE_B;
			end
			xxh32_pkg::S_LANE_B: begin
				cmd.op = xxh32_pkg::OP_LANE_B;
				if (idx_q == 2'd3) begin
					idx_d   = 2'd0;
					state_d = stat.last ? xxh32_pkg::S_INIT : xxh32_pkg::S_IDLE;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = xxh32_pkg::S_LANE_A;
				end
			end
			xxh32_pkg::S_INIT: begin
				cmd.op = xxh32_pkg::OP_INIT;
				idx_d  = 2'd0;
				if (stat.pcnt != 2'd0)
					state_d = xxh32_pkg::S_PEND_A;
				else if (stat.tail != 2'd0)
					state_d = xxh32_pkg::S_BYTE_A;
				else
					state_d = xxh32_pkg::S_AVAL_A;
			end
			xxh32_pkg::S_PEND_A: begin
				cmd.op  = xxh32_pkg::OP_PEND_A;
				state_d = xxh32_pkg::S_PEND_B;
			end
			xxh32_pkg::S_PEND_B: begin
				cmd.op = xxh32_pkg::OP_PEND_B;
				if (idx_q + 2'd1 == stat.pcnt) begin
					idx_d   = 2'd0;
					state_d = (stat.tail != 2'd0) ? xxh32_pkg::S_BYTE_A
						: xxh32_pkg::S_AVAL_A;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = xxh32_pkg::S_PEND_A;
				end
			end
			xxh32_pkg::S_BYTE_A: begin
				cmd.op  = xxh32_pkg::OP_BYTE_A;
				state_d = xxh32_pkg::S_BYTE_B;
			end
			xxh32_pkg::S_BYTE_B: begin
				cmd.op = xxh32_pkg::OP_BYTE_B;
				if (idx_q + 2'd1 == stat.tail) begin
					idx_d   = 2'd0;
					state_d = xxh32_pkg::S_AVAL_A;
				end else begin
					idx_d   = idx_q + 2'd1;
					state_d = xxh32_pkg::S_BYTE_A;
				end
			end
			xxh32_pkg::S_AVAL_A: begin
				cmd.op  = xxh32_pkg::OP_AVAL_A;
				state_d = xxh32_pkg::S_AVAL_B;
			end
			xxh32_pkg::S_AVAL_B: begin
				cmd.op  = xxh32_pkg::OP_AVAL_B;
				state_d = xxh32_pkg::S_OUT;
			end
			xxh32_pkg::S_OUT: begin
				// wait for the output register to be free
				if (stat.out_free) begin
					cmd.op  = xxh32_pkg::OP_OUT;
					state_d = xxh32_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = xxh32_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### src/xxh32_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxh32_dp
// Datapath: lane accumulators, stripe buffer, length count, one shared
// registered 32x32 constant multiplier and the output register.
// ----------------------------------------------------------------------------
module xxh32_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         seed,
	input  logic [31:0]         data_word,
	input  logic [2:0]          byte_count,
	input  logic                last,
	input  logic                hash_stall,
	output logic                hash_valid,
	output logic [31:0]         hash,
	input  xxh32_pkg::dp_cmd_t  cmd,
	output xxh32_pkg::dp_stat_t stat
);

	// control state
	logic        at_start_q;
	logic [1:0]  pcnt_q;
	logic [31:0] len_q;
	logic        stripe_q;
	logic        lane_wb_q;
	logic        h_wb_q;
	logic        hv_q;

	// payload
	logic [31:0] lane_q [4];
	logic [31:0] pend_q [3];
	logic [31:0] seed_q;
	logic [31:0] word_q;
	logic [1:0]  tail_q;
	logic        last_q;
	logic [31:0] mul_q;
	logic [31:0] h_q;
	logic [1:0]  wb_idx_q;
	logic [31:0] hash_q;

	logic [1:0]  pcnt_e;
	logic [31:0] len_e;
	logic        stripe_e;
	logic [2:0]  nbytes;
	logic        full;
	logic [31:0] lane_e [4];
	logic [31:0] h_e;
	logic [31:0] pend_rd;
	logic [31:0] lane_w;
	logic [31:0] merge;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [7:0]  tail_byte;
	logic        out_free;

	// message state as seen by the item being accepted
	assign pcnt_e   = at_start_q ? 2'd0 : pcnt_q;
	assign len_e    = at_start_q ? 32'd0 : len_q;
	assign stripe_e = at_start_q ? 1'b0 : stripe_q;
	assign nbytes   = (!last || byte_count >= 3'd4) ? 3'd4 : byte_count;
	assign full     = (nbytes == 3'd4);

	// forward multiplier results that are still on their way back
	always_comb begin
		for (int i = 0; i < 4; i++)
			lane_e[i] = (lane_wb_q && wb_idx_q == 2'(i)) ? mul_q : lane_q[i];
	end
	assign h_e = h_wb_q ? mul_q : h_q;

	// stripe buffer read
	always_comb begin
		case (cmd.idx)
			2'd0:    pend_rd = pend_q[0];
			2'd1:    pend_rd = pend_q[1];
			default: pend_rd = pend_q[2];
		endcase
	end
	assign lane_w    = (cmd.idx == 2'd3) ? word_q : pend_rd;
	assign tail_byte = 8'(word_q >> {cmd.idx, 3'b000});

	// lane merge
	assign merge = xxh32_pkg::rotl(lane_e[0], 1) + xxh32_pkg::rotl(lane_e[1], 7)
		+ xxh32_pkg::rotl(lane_e[2], 12) + xxh32_pkg::rotl(lane_e[3], 18);

	// multiplier operand selection
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (cmd.op)
			xxh32_pkg::OP_LANE_A: begin
				mul_a = lane_w;
				mul_b = xxh32_pkg::PRIME2;
			end
			xxh32_pkg::OP_LANE_B: begin
				mul_a = xxh32_pkg::rotl(lane_e[cmd.idx] + mul_q, 13);
				mul_b = xxh32_pkg::PRIME1;
			end
			xxh32_pkg::OP_PEND_A: begin
				mul_a = pend_rd;
				mul_b = xxh32_pkg::PRIME3;
			end
			xxh32_pkg::OP_PEND_B: begin
				mul_a = xxh32_pkg::rotl(h_e + mul_q, 17);
				mul_b = xxh32_pkg::PRIME4;
			end
			xxh32_pkg::OP_BYTE_A: begin
				mul_a = {24'd0, tail_byte};
				mul_b = xxh32_pkg::PRIME5;
			end
			xxh32_pkg::OP_BYTE_B: begin
				mul_a = xxh32_pkg::rotl(h_e + mul_q, 11);
				mul_b = xxh32_pkg::PRIME1;
			end
			xxh32_pkg::OP_AVAL_A: begin
				mul_a = h_e ^ (h_e >> 15);
				mul_b = xxh32_pkg::PRIME2;
			end
			xxh32_pkg::OP_AVAL_B: begin
				mul_a = mul_q ^ (mul_q >> 13);
				mul_b = xxh32_pkg::PRIME3;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	// shared multiplier, registered; the product holds while no command is issued
	always_ff @(posedge clk) begin
		if (cmd.op != xxh32_pkg::OP_NONE)
			mul_q <= 32'(mul_a * mul_b);
	end

	// message control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			pcnt_q     <= 2'd0;
			len_q      <= 32'd0;
			stripe_q   <= 1'b0;
			lane_wb_q  <= 1'b0;
			h_wb_q     <= 1'b0;
			hv_q       <= 1'b0;
		end else begin
			lane_wb_q <= (cmd.op == xxh32_pkg::OP_LANE_B);
			h_wb_q    <= (cmd.op == xxh32_pkg::OP_PEND_B) || (cmd.op == xxh32_pkg::OP_BYTE_B);
			if (cmd.op == xxh32_pkg::OP_LOAD) begin
				at_start_q <= 1'b0;
				len_q      <= len_e + {29'd0, nbytes};
				if (full && pcnt_e == 2'd3) begin
					pcnt_q   <= 2'd0;
					stripe_q <= 1'b1;
				end else begin
					pcnt_q   <= full ? pcnt_e + 2'd1 : pcnt_e;
					stripe_q <= stripe_e;
				end
			end else if (cmd.op == xxh32_pkg::OP_OUT) begin
				at_start_q <= 1'b1;
			end
			// output register
			if (cmd.op == xxh32_pkg::OP_OUT)
				hv_q <= 1'b1;
			else if (!hash_stall)
				hv_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == xxh32_pkg::OP_LOAD) begin
			word_q <= data_word;
			last_q <= last;
			tail_q <= full ? 2'd0 : nbytes[1:0];
			if (full && pcnt_e != 2'd3)
				pend_q[pcnt_e] <= data_word;
		end
		if (cmd.op == xxh32_pkg::OP_LOAD && at_start_q) begin
			seed_q    <= seed;
			lane_q[0] <= seed + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
			lane_q[1] <= seed + xxh32_pkg::PRIME2;
			lane_q[2] <= seed;
			lane_q[3] <= seed - xxh32_pkg::PRIME1;
		end else if (lane_wb_q) begin
			lane_q[wb_idx_q] <= mul_q;
		end
		if (cmd.op == xxh32_pkg::OP_LANE_B)
			wb_idx_q <= cmd.idx;
		if (cmd.op == xxh32_pkg::OP_INIT)
			h_q <= (stripe_q ? merge : seed_q + xxh32_pkg::PRIME5) + len_q;
		else if (h_wb_q)
			h_q <= mul_q;
		if (cmd.op == xxh32_pkg::OP_OUT)
			hash_q <= mul_q ^ (mul_q >> 16);
	end

	assign out_free = !hv_q || !hash_stall;

	// status to the controller
	assign stat.full_stripe = full && (pcnt_e == 2'd3);
	assign stat.item_last   = last;
	assign stat.pcnt        = pcnt_q;
	assign stat.tail        = tail_q;
	assign stat.last        = last_q;
	assign stat.out_free    = out_free;

	assign hash_valid = hv_q;
	assign hash       = hash_q;

endmodule

### src/xxhash32_stream_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xxhash32_stream_chk
// Port-level checks on the streaming hash block, bound to the top level.
// ----------------------------------------------------------------------------
module xxhash32_stream_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic [31:0] seed,
	input logic [31:0] data_word,
	input logic [2:0]  byte_count,
	input logic        last,
	input logic        hash_valid,
	input logic        hash_stall,
	input logic [31:0] hash
);

	// a stalled hash holds
	a_hash_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hash_valid && hash_stall |=> hash_valid && $stable(hash))
		else $error("stalled hash changed");

	// finishing a message blocks the input
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && last |=> item_stall)
		else $error("input taken during finish");

	// a new hash comes only out of the finishing sequence
	a_rose_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash_valid) |-> $past(item_stall))
		else $error("hash appeared without finish");

	// a word that is not last never produces a hash straight away
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && !last && !hash_valid |=> !hash_valid)
		else $error("hash without last transfer");

endmodule

bind xxhash32_stream xxhash32_stream_chk u_chk (.*);
